/* sv/rtsb_pkg.sv */
// ----------------------------------------------------------------------------
// rtsb_pkg
// Shared constants, opcodes and cell command/response types for the
// reloading timer slot bank.
// ----------------------------------------------------------------------------
package rtsb_pkg;

  localparam int NumSlots   = 6;
  localparam int CountWidth = 32;
  localparam int SlotW      = 3;
  localparam int PendW      = 8;
  localparam int OpW        = 3;
  localparam int FieldW     = 32;

  localparam logic [OpW-1:0] OpTick    = 3'd0;
  localparam logic [OpW-1:0] OpService = 3'd1;
  localparam logic [OpW-1:0] OpAdd     = 3'd2;
  localparam logic [OpW-1:0] OpRemove  = 3'd3;
  localparam logic [OpW-1:0] OpQuery   = 3'd4;

  // Command broadcast to every cell for one accepted transfer.
  typedef struct packed {
    logic                  accept;
    logic [OpW-1:0]        op;
    logic [SlotW-1:0]      slot_index;
    logic [SlotW-1:0]      svc_slot;
    logic [CountWidth-1:0] start;
    logic [CountWidth-1:0] reload;
  } cell_cmd_t;

  // Response contribution of one cell; the top level ORs them together.
  typedef struct packed {
    logic             take;
    logic             ok;
    logic [SlotW-1:0] slot;
    logic             fired;
    logic [PendW-1:0] pending;
  } cell_rsp_t;

endpackage

/* sv/rtsb_cell.sv */
// ----------------------------------------------------------------------------
// rtsb_cell
// One timer slot: down-counter, reload value, pending-expiry count and the
// allocation bit, plus its link in the first-free allocation chain.
// ----------------------------------------------------------------------------
module rtsb_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [rtsb_pkg::SlotW-1:0] idx_i,
  input  rtsb_pkg::cell_cmd_t       cmd_i,
  input  logic                      taken_i,
  output logic                      taken_o,
  output rtsb_pkg::cell_rsp_t       rsp_o
);
  import rtsb_pkg::*;

  logic                  valid_q, valid_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] reload_q, reload_d;
  logic [PendW-1:0]      pend_q, pend_d;

  logic                  tick_hit, svc_hit, add_hit, rem_hit, qry_hit, fire;
  logic [CountWidth-1:0] count_dec;
  logic [PendW-1:0]      pend_dec;

  assign taken_o   = taken_i | ~valid_q;
  assign tick_hit  = cmd_i.accept && (cmd_i.op == OpTick) && valid_q && (count_q != '0);
  assign svc_hit   = cmd_i.accept && (cmd_i.op == OpService) && (cmd_i.svc_slot == idx_i);
  assign add_hit   = cmd_i.accept && (cmd_i.op == OpAdd) && !valid_q && !taken_i;
  assign rem_hit   = cmd_i.accept && (cmd_i.op == OpRemove) && (cmd_i.slot_index == idx_i);
  assign qry_hit   = (cmd_i.op == OpQuery) && (cmd_i.slot_index == idx_i);
  assign fire      = svc_hit && valid_q && (pend_q != '0);
  assign count_dec = count_q - CountWidth'(1);
  assign pend_dec  = pend_q - PendW'(1);

  always_comb begin
    valid_d  = valid_q;
    count_d  = count_q;
    reload_d = reload_q;
    pend_d   = pend_q;
    if (tick_hit) begin
      if (count_dec == '0) begin
        count_d = reload_q;
        if (pend_q != '1) begin
          pend_d = pend_q + PendW'(1);
        end
      end else begin
        count_d = count_dec;
      end
    end
    if (fire) begin
      pend_d = pend_dec;
      // A stopped slot with nothing left to report is released.
      if ((count_q == '0) && (pend_dec == '0)) begin
        valid_d = 1'b0;
      end
    end
    if (add_hit) begin
      valid_d  = 1'b1;
      count_d  = cmd_i.start;
      reload_d = cmd_i.reload;
      pend_d   = '0;
    end
    if (rem_hit) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    rsp_o         = '0;
    rsp_o.take    = add_hit;
    rsp_o.ok      = add_hit | (qry_hit & valid_q);
    rsp_o.slot    = (add_hit | svc_hit) ? idx_i : '0;
    rsp_o.fired   = fire;
    rsp_o.pending = fire ? pend_dec : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    reload_q <= reload_d;
    pend_q   <= pend_d;
  end

endmodule

/* sv/reloading_timer_slot_bank_unit.sv */
// ----------------------------------------------------------------------------
// reloading_timer_slot_bank_unit
// A bank of reloading timer slots built as a row of slot cells.
// ----------------------------------------------------------------------------
// Output: a result appears in the cycle after its item transfer, from the
// output register.
// Throughput: one item per cycle unless a stalled result holds the input;
// every cell and the allocation chain settle within the accepting cycle.
// Reset: all slots are free, the service pointer sits on the last slot so
// the first service examines slot 0, and no result is held.
module reloading_timer_slot_bank_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rtsb_pkg::OpW-1:0]    opcode_i,
  input  logic [rtsb_pkg::SlotW-1:0]  slot_index_i,
  input  logic [rtsb_pkg::FieldW-1:0] start_count_i,
  input  logic [rtsb_pkg::FieldW-1:0] reload_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [rtsb_pkg::SlotW-1:0]  slot_out_o,
  output logic                        fired_o,
  output logic [rtsb_pkg::PendW-1:0]  pending_left_o
);
  import rtsb_pkg::*;

  logic                 accept;
  logic [SlotW-1:0]     ptr_q, ptr_d, ptr_next;
  cell_cmd_t            cmd;
  cell_rsp_t            rsp [NumSlots];
  cell_rsp_t            rsp_all;
  logic [NumSlots:0]    taken;
  logic [NumSlots-1:0]  take_vec;

  logic                 out_valid_q;
  logic                 ok_q;
  logic [SlotW-1:0]     slot_q;
  logic                 fired_q;
  logic [PendW-1:0]     pend_q;

  // The input side is held only while a finished result waits on a stalled
  // output. Otherwise the output register frees up in the same cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Round-robin service pointer wraps at the last slot.
  assign ptr_next = (ptr_q == SlotW'(NumSlots - 1)) ? '0 : ptr_q + SlotW'(1);
  assign ptr_d    = (accept && (opcode_i == OpService)) ? ptr_next : ptr_q;

  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.op         = opcode_i;
    cmd.slot_index = slot_index_i;
    cmd.svc_slot   = ptr_next;
    cmd.start      = start_count_i[CountWidth-1:0];
    cmd.reload     = reload_value_i[CountWidth-1:0];
  end

  // The first-free chain starts with nothing taken; each cell passes on
  // whether it or any earlier cell is free.
  assign taken[0] = 1'b0;

  for (genvar i = 0; i < NumSlots; i++) begin : g_cell
    rtsb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (SlotW'(i)),
      .cmd_i   (cmd),
      .taken_i (taken[i]),
      .taken_o (taken[i+1]),
      .rsp_o   (rsp[i])
    );
    assign take_vec[i] = rsp[i].take;
  end

  // At most one cell responds to any item, so an OR merges the responses.
  always_comb begin
    rsp_all = '0;
    for (int i = 0; i < NumSlots; i++) begin
      rsp_all = rsp_all | rsp[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= SlotW'(NumSlots - 1);
      out_valid_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= rsp_all.ok;
      slot_q  <= rsp_all.slot;
      fired_q <= rsp_all.fired;
      pend_q  <= rsp_all.pending;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign slot_out_o     = slot_q;
  assign fired_o        = fired_q;
  assign pending_left_o = pend_q;

`ifndef ASSERT_OFF
  a_ptr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= SlotW'(NumSlots - 1))
    else $error("service pointer beyond last slot");

  a_one_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(take_vec))
    else $error("more than one slot allocated by one add");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted transfer produced no result");

  a_fired_not_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fired_o) |-> !ok_o)
    else $error("fired service result also flags ok");

  a_ptr_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i != OpService)) |=> $stable(ptr_q))
    else $error("service pointer moved without a service transfer");
`endif

endmodule

/* verif/reloading_timer_slot_bank_checker.sv */
// ----------------------------------------------------------------------------
// reloading_timer_slot_bank_checker
// Watches both channels of the timer slot bank, keeps its own copy of the
// slot state, predicts one report per accepted item and compares each
// returned report with the oldest prediction.
// ----------------------------------------------------------------------------
module reloading_timer_slot_bank_checker
  import rtsb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [OpW-1:0]    opcode_i,
  input  logic [SlotW-1:0]  slot_index_i,
  input  logic [FieldW-1:0] start_count_i,
  input  logic [FieldW-1:0] reload_value_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              ok_i,
  input  logic [SlotW-1:0]  slot_out_i,
  input  logic              fired_i,
  input  logic [PendW-1:0]  pending_left_i,
  output int                fail_count_o,
  output int                outstanding_o
);

  localparam int MaxReports = 40;

  typedef struct packed {
    logic             ok;
    logic [SlotW-1:0] slot;
    logic             fired;
    logic [PendW-1:0] pending;
  } slot_report_t;

  // Shadow copy of the bank.
  logic                  armed      [NumSlots];
  logic [CountWidth-1:0] remaining  [NumSlots];
  logic [CountWidth-1:0] reload_copy[NumSlots];
  logic [PendW-1:0]      backlog    [NumSlots];
  logic [SlotW-1:0]      svc_ptr;

  slot_report_t slot_report_q[$];
  int           miscompares;
  int           awaiting;

  assign fail_count_o  = miscompares;
  assign outstanding_o = awaiting;

  function automatic slot_report_t apply_timer_op(
    input logic [OpW-1:0]    op,
    input logic [SlotW-1:0]  idx,
    input logic [FieldW-1:0] start,
    input logic [FieldW-1:0] reload
  );
    slot_report_t rep;
    int           p;
    bit           placed;
    rep    = '0;
    placed = 1'b0;
    case (op)
      OpTick: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (armed[i] && remaining[i] != '0) begin
            remaining[i] = remaining[i] - 1'b1;
            if (remaining[i] == '0) begin
              if (backlog[i] != '1) backlog[i] = backlog[i] + 1'b1;
              remaining[i] = reload_copy[i];
            end
          end
        end
      end
      OpService: begin
        p = (int'(svc_ptr) + 1 >= NumSlots) ? 0 : int'(svc_ptr) + 1;
        svc_ptr  = SlotW'(p);
        rep.slot = SlotW'(p);
        if (armed[p] && backlog[p] != '0) begin
          backlog[p]  = backlog[p] - 1'b1;
          rep.fired   = 1'b1;
          rep.pending = backlog[p];
          // A stopped slot with nothing left to report goes back to the pool.
          if (remaining[p] == '0 && backlog[p] == '0) armed[p] = 1'b0;
        end
      end
      OpAdd: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (!placed && !armed[i]) begin
            placed         = 1'b1;
            armed[i]       = 1'b1;
            remaining[i]   = start[CountWidth-1:0];
            reload_copy[i] = reload[CountWidth-1:0];
            backlog[i]     = '0;
            rep.ok         = 1'b1;
            rep.slot       = SlotW'(i);
          end
        end
      end
      OpRemove: begin
        if (int'(idx) < NumSlots) armed[idx] = 1'b0;
      end
      OpQuery: begin
        if (int'(idx) < NumSlots && armed[idx]) rep.ok = 1'b1;
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      miscompares++;
      if (miscompares <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    slot_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        armed[i]       = 1'b0;
        remaining[i]   = '0;
        reload_copy[i] = '0;
        backlog[i]     = '0;
      end
      svc_ptr = SlotW'(NumSlots - 1);
      slot_report_q.delete();
      awaiting = 0;
    end else begin
      // A report always trails its item, so compare before predicting.
      if (out_valid_i && !out_stall_i) begin
        if (slot_report_q.size() == 0) begin
          miscompares++;
          if (miscompares <= MaxReports) begin
            $display("%0t: report with nothing expected, actual ok=%0b slot=%0d",
                     $time, ok_i, slot_out_i);
          end
        end else begin
          want = slot_report_q.pop_front();
          check_field("ok", want.ok, ok_i);
          check_field("slot_out", want.slot, slot_out_i);
          check_field("fired", want.fired, fired_i);
          check_field("pending_left", want.pending, pending_left_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        slot_report_q.push_back(apply_timer_op(opcode_i, slot_index_i,
                                               start_count_i, reload_value_i));
      end
      awaiting = slot_report_q.size();
    end
  end

endmodule

/* verif/reloading_timer_slot_bank_unit_test.sv */
// ----------------------------------------------------------------------------
// reloading_timer_slot_bank_unit_test
// Drives the timer slot bank with a directed opening and a long random mix
// of ticks, services, adds, removes and queries, with random gaps on both
// channels; a checker beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module reloading_timer_slot_bank_unit_test;
  import rtsb_pkg::*;

  // Largest opcode value the field can carry; everything above OpQuery
  // is unused and must leave the bank alone.
  localparam logic [OpW-1:0] OpTopCode = '1;
  localparam int RandomItems   = 1300;
  localparam int BlockItems    = 100;
  localparam int HoldOffCycles = 80;
  localparam int DrainCycles   = 4;
  localparam int CycleLimit    = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OpW-1:0]    opcode_i;
  logic [SlotW-1:0]  slot_index_i;
  logic [FieldW-1:0] start_count_i;
  logic [FieldW-1:0] reload_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              ok_o;
  logic [SlotW-1:0]  slot_out_o;
  logic              fired_o;
  logic [PendW-1:0]  pending_left_o;

  int fail_count;
  int outstanding;
  int cycle_count = 0;

  // Sender and receiver talk through these: the sender asks for a long
  // receiver hold-off, and the receiver process counts it out on its own.
  int hold_off_asked  = 0;
  int hold_off_served = 0;
  bit steady_send     = 1'b0;

  always #6 clk_i = ~clk_i;

  reloading_timer_slot_bank_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .slot_index_i   (slot_index_i),
    .start_count_i  (start_count_i),
    .reload_value_i (reload_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .slot_out_o     (slot_out_o),
    .fired_o        (fired_o),
    .pending_left_o (pending_left_o)
  );

  reloading_timer_slot_bank_checker bank_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .opcode_i       (opcode_i),
    .slot_index_i   (slot_index_i),
    .start_count_i  (start_count_i),
    .reload_value_i (reload_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_i           (ok_o),
    .slot_out_i     (slot_out_o),
    .fired_i        (fired_o),
    .pending_left_i (pending_left_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // Counts are mostly small so that slots actually expire during the run,
  // with full-width values and the extremes mixed in so every bit toggles.
  function automatic logic [FieldW-1:0] pick_count(input int small_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return FieldW'($urandom_range(0, small_max));
    if (r < 85) return $urandom;
    if (r < 92) return '1;
    if (r < 96) return FieldW'(1);
    return '0;
  endfunction

  // Offers one transfer and returns just after the edge that accepted it.
  // The stall is sampled at the falling edge, where it has settled, so the
  // decision never depends on event order at the rising edge. After the
  // transfer the sender may go quiet for a random gap.
  task automatic send(input logic [OpW-1:0] op, input logic [SlotW-1:0] idx,
                      input logic [FieldW-1:0] start, input logic [FieldW-1:0] reload);
    logic stalled;
    int   gap;
    int   r;
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    slot_index_i   <= idx;
    start_count_i  <= start;
    reload_value_i <= reload;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    gap = 0;
    if (!steady_send) begin
      r = $urandom_range(0, 99);
      if (r < 3) gap = $urandom_range(10, 30);
      else if (r < 30) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender until every predicted report has come back. The valid
  // is dropped first so the last item is not offered again, and the wait
  // starts only once the checker's count already covers the last transfer.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    @(posedge clk_i);
  endtask

  // One random item. The mix leans on ticks and services so that the slots
  // added here run down, fire, reload and get reported; removes, queries
  // and the unused opcodes supply the noise.
  task automatic send_random_item();
    int               r;
    logic [OpW-1:0]   op;
    logic [SlotW-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 36) op = OpTick;
    else if (r < 64) op = OpService;
    else if (r < 78) op = OpAdd;
    else if (r < 87) op = OpRemove;
    else if (r < 95) op = OpQuery;
    else op = OpW'($urandom_range(int'(OpQuery) + 1, int'(OpTopCode)));
    // Remove and query mostly address real slots, sometimes the unused ones.
    if ($urandom_range(0, 99) < 85) idx = SlotW'($urandom_range(0, NumSlots - 1));
    else idx = SlotW'($urandom);
    send(op, idx, pick_count(6), pick_count(4));
  endtask

  // Receiver: random stalls, mostly short with a few long ones, calm
  // stretches with no stall at all, and the long hold-off on request.
  initial begin : receiver
    int  r;
    int  stall_len;
    bit  calm;
    calm = 1'b0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_asked != hold_off_served) begin
        hold_off_served++;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 149) == 0) calm = !calm;
        stall_len = 0;
        if (!calm) begin
          r = $urandom_range(0, 99);
          if (r < 2) stall_len = $urandom_range(10, 30);
          else if (r < 22) stall_len = $urandom_range(1, 3);
        end
        if (stall_len > 0) begin
          out_stall_i <= 1'b1;
          repeat (stall_len) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost report ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    in_valid_i     <= 1'b0;
    opcode_i       <= OpTick;
    slot_index_i   <= '0;
    start_count_i  <= '0;
    reload_value_i <= '0;
    rst_ni         <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. Queries and a service on the empty bank, including
    // an index past the last slot, then the bank is filled with one-shot,
    // never-running, longest-count and fast reloading timers.
    send(OpQuery, '0, '1, '1);
    send(OpQuery, '1, '0, '0);
    send(OpService, '1, '1, '1);          // free slot 0: pointer moves, empty report
    send(OpAdd, '0, FieldW'(1), '0);      // slot 0, one-shot
    send(OpAdd, '0, '0, FieldW'(5));      // slot 1, start 0 never runs
    send(OpAdd, '1, FieldW'(2), '1);      // slot 2, reloads to the widest count
    send(OpAdd, '0, '1, FieldW'(1));      // slot 3, widest start count
    send(OpAdd, '0, FieldW'(1), FieldW'(1));
    send(OpAdd, '0, FieldW'(3), FieldW'(2));
    send(OpAdd, '1, '1, '1);              // bank full: refused
    send(OpTick, '1, '1, '1);
    send(OpTick, '0, '0, '0);
    // Walk the pointer over slots 1 to 5 and back to 0. Slot 1 has nothing
    // pending and stays allocated; slot 0 fires its single expiry and,
    // being stopped, is freed.
    repeat (NumSlots) send(OpService, '0, '0, '0);
    send(OpQuery, SlotW'(0), '0, '0);
    send(OpQuery, SlotW'(1), '0, '0);
    send(OpRemove, SlotW'(NumSlots), '0, '0);   // past the last slot
    send(OpRemove, SlotW'(0), '0, '0);          // already free
    send(OpRemove, SlotW'(1), '1, '1);
    send(OpQuery + 1'b1, '1, '1, '1);
    send(OpTopCode, '0, '1, '0);

    // The sender waits here until the bank has answered everything.
    drain_reports();

    // Random part in blocks of items. Some blocks send back to back, the
    // rest with random gaps. Early on the receiver is asked for a long
    // hold-off so the output side backs up into the input stall.
    for (int b = 0; b < RandomItems / BlockItems; b++) begin
      steady_send = ($urandom_range(0, 3) == 0);
      if (b == 1) hold_off_asked++;
      if (b == 8) drain_reports();
      if (b == 5) begin
        // Pending saturation: clear the bank, load every slot with a
        // one-tick reloading timer and tick past 255 expiries, then let
        // service report the saturated backlog.
        for (int s = 0; s < NumSlots; s++) send(OpRemove, SlotW'(s), '0, '0);
        for (int s = 0; s < NumSlots; s++) send(OpAdd, '0, FieldW'(1), FieldW'(1));
        repeat (270) send(OpTick, SlotW'($urandom), $urandom, $urandom);
        repeat (NumSlots + 2) send(OpService, SlotW'($urandom), $urandom, $urandom);
        for (int s = 0; s < NumSlots; s += 2) send(OpRemove, SlotW'(s), '0, '0);
      end
      repeat (BlockItems) send_random_item();
    end

    drain_reports();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
